// File: hdl/assert_macros.svh
// Assertion macros used by the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition holds on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Check that an antecedent is followed by a consequent (any property operator)
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`endif

// File: hdl/rrts_pkg.sv
// Types and constants of the round-robin task scheduler
`default_nettype none
package rrts_pkg;

  typedef enum logic [2:0] {
    K_TICK    = 3'd0,
    K_CREATE  = 3'd1,
    K_BLOCK   = 3'd2,
    K_UNBLOCK = 3'd3,
    K_PRIO    = 3'd4,
    K_REMOVE  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_NO_SLOT    = 3'd1,
    STS_ZERO_ENTRY = 3'd2,
    STS_NOT_FOUND  = 3'd3,
    STS_PROTECTED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RS_READY   = 2'd0,
    RS_RUNNING = 2'd1,
    RS_BLOCKED = 2'd2
  } run_e;

  localparam logic [31:0] FIRST_ID   = 32'd9123;
  localparam logic [7:0]  FULL_SLICE = 8'd255;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] task_id;
    logic [7:0]  priority_req;
    logic [31:0] entry_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  running_slot;
    logic [31:0] running_id;
    logic        switched;
    logic [31:0] created_id;
  } rsp_t;

  typedef struct packed {
    logic        active;
    logic [1:0]  state;
    logic [31:0] id;
    logic [7:0]  slice;
    logic [7:0]  ticks;
  } slot_t;

  localparam slot_t SLOT0_INIT = '{active: 1'b1, state: RS_RUNNING, id: FIRST_ID,
                                   slice: FULL_SLICE, ticks: FULL_SLICE};

endpackage
`default_nettype wire

// File: hdl/rrts_if.sv
// Request and response channel interfaces of the scheduler
`default_nettype none
interface rrts_req_if import rrts_pkg::*;;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module rrts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: hdl/rrts_seq.sv
// Scheduler sequencer: slot scans, reschedule and task table updates
`default_nettype none
`include "assert_macros.svh"
module rrts_seq import rrts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output rsp_t      res_o
);
  localparam int unsigned SlotW = $clog2(TASK_SLOTS);
  localparam int unsigned CntW  = $clog2(TASK_SLOTS + 1);
  typedef logic [SlotW-1:0] slot_idx_t;
  localparam slot_idx_t LastSlot = slot_idx_t'(TASK_SLOTS - 1);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RCUR  = 4'd2;
  localparam logic [3:0] ST_DECR  = 4'd3;
  localparam logic [3:0] ST_SCAN  = 4'd4;
  localparam logic [3:0] ST_SRCH  = 4'd5;
  localparam logic [3:0] ST_WCUR  = 4'd6;
  localparam logic [3:0] ST_WCAND = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  function automatic slot_idx_t next_slot(slot_idx_t i);
    return (i == LastSlot) ? '0 : slot_idx_t'(i + 1'b1);
  endfunction

  logic [3:0]  state_q, state_d;
  logic [2:0]  kind_q;
  logic [31:0] id_in_q;
  logic [7:0]  prio_q;
  logic [31:0] entry_q;
  slot_idx_t   clr_q;
  slot_idx_t   iss_idx_q, iss_idx_d;
  logic [CntW-1:0] iss_cnt_q, iss_cnt_d;
  logic        pend_q, pend_d;
  slot_idx_t   pidx_q;
  logic        plast_q;
  slot_idx_t   cur_slot_q;
  logic [31:0] cur_id_q;
  logic [31:0] id_ctr_q;
  slot_t       cur_rec_q, cur_rec_d;
  slot_idx_t   cand_q;
  slot_t       cand_rec_q;
  logic [2:0]  status_q, status_d;
  logic [31:0] created_q;
  logic        sw_q;

  logic        we, re, issue, hit, scanning, create_ok;
  slot_idx_t   waddr, raddr;
  slot_t       wdata, rdata, rec_sel, rec_mod, dec_rec;

  rrts_ram #(.WIDTH($bits(slot_t)), .DEPTH(TASK_SLOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);
  assign scanning    = (state_q == ST_SCAN) || (state_q == ST_SRCH);
  assign issue       = scanning && (iss_cnt_q != CntW'(TASK_SLOTS));

  always_comb begin
    rec_sel = rdata;
    if (state_q == ST_SRCH && pidx_q == cur_slot_q) begin
      rec_sel = cur_rec_q;
    end
  end

  always_comb begin
    hit = 1'b0;
    if (state_q == ST_SRCH) begin
      hit = rec_sel.active && (rec_sel.state == RS_READY || rec_sel.state == RS_RUNNING);
    end else if (kind_q == K_CREATE) begin
      hit = !rec_sel.active;
    end else begin
      hit = rec_sel.active && (rec_sel.id == id_in_q);
    end
    hit = hit && pend_q;
  end

  always_comb begin
    dec_rec = cur_rec_q;
    if (cur_rec_q.ticks != 8'd0) begin
      dec_rec.ticks = cur_rec_q.ticks - 8'd1;
    end
  end

  always_comb begin
    rec_mod = rec_sel;
    case (kind_q)
      K_BLOCK:   rec_mod.state = RS_BLOCKED;
      K_UNBLOCK: begin
        rec_mod.state = RS_READY;
        rec_mod.ticks = rec_sel.slice;
      end
      K_PRIO: begin
        rec_mod.slice = prio_q;
        rec_mod.ticks = prio_q;
      end
      K_REMOVE:  rec_mod = '0;
      default:   rec_mod = '{active: 1'b1, state: RS_READY, id: id_ctr_q,
                             slice: prio_q, ticks: prio_q};
    endcase
  end

  assign create_ok = (entry_q != 32'd0);

  always_comb begin
    state_d   = state_q;
    we        = 1'b0;
    waddr     = cur_slot_q;
    wdata     = cur_rec_q;
    re        = 1'b0;
    raddr     = iss_idx_q;
    iss_idx_d = iss_idx_q;
    iss_cnt_d = iss_cnt_q;
    pend_d    = 1'b0;
    cur_rec_d = cur_rec_q;
    status_d  = status_q;
    if (issue) begin
      re        = 1'b1;
      iss_idx_d = next_slot(iss_idx_q);
      iss_cnt_d = iss_cnt_q + 1'b1;
      pend_d    = 1'b1;
    end
    case (state_q)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = (clr_q == '0) ? SLOT0_INIT : '0;
        if (clr_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        status_d = STS_OK;
        if (req_valid_i) begin
          iss_idx_d = '0;
          iss_cnt_d = '0;
          if (req_i.kind == K_TICK) begin
            re      = 1'b1;
            raddr   = cur_slot_q;
            state_d = ST_RCUR;
          end else if (req_i.kind >= K_CREATE && req_i.kind <= K_REMOVE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_RCUR: begin
        cur_rec_d = rdata;
        state_d   = ST_DECR;
      end
      ST_DECR: begin
        if (dec_rec.ticks != 8'd0 && dec_rec.state == RS_RUNNING) begin
          we      = 1'b1;
          wdata   = dec_rec;
          state_d = ST_OUT;
        end else begin
          cur_rec_d = dec_rec;
          iss_idx_d = next_slot(cur_slot_q);
          iss_cnt_d = '0;
          state_d   = ST_SRCH;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          pend_d  = 1'b0;
          state_d = ST_OUT;
          if (kind_q == K_CREATE) begin
            if (!create_ok) begin
              status_d = STS_ZERO_ENTRY;
            end else begin
              we    = 1'b1;
              waddr = pidx_q;
              wdata = rec_mod;
            end
          end else if (kind_q == K_REMOVE && rec_sel.id == FIRST_ID) begin
            status_d = STS_PROTECTED;
          end else if ((kind_q == K_BLOCK || kind_q == K_REMOVE) && pidx_q == cur_slot_q) begin
            cur_rec_d = rec_mod;
            state_d   = ST_DECR;
          end else begin
            we    = 1'b1;
            waddr = pidx_q;
            wdata = rec_mod;
          end
        end else if (pend_q && plast_q) begin
          pend_d   = 1'b0;
          status_d = (kind_q == K_CREATE) ? STS_NO_SLOT : STS_NOT_FOUND;
          state_d  = ST_OUT;
        end
      end
      ST_SRCH: begin
        if (hit) begin
          pend_d  = 1'b0;
          state_d = ST_WCUR;
        end else if (pend_q && plast_q) begin
          pend_d      = 1'b0;
          we          = 1'b1;
          wdata       = cur_rec_q;
          wdata.ticks = cur_rec_q.slice;
          state_d     = ST_OUT;
        end
      end
      ST_WCUR: begin
        we = 1'b1;
        if (cur_rec_q.state == RS_RUNNING) begin
          wdata.state = RS_READY;
        end
        state_d = ST_WCAND;
      end
      ST_WCAND: begin
        we      = 1'b1;
        waddr   = cand_q;
        wdata   = cand_rec_q;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_q      <= '0;
      pend_q     <= 1'b0;
      iss_cnt_q  <= '0;
      cur_slot_q <= '0;
      cur_id_q   <= FIRST_ID;
      id_ctr_q   <= FIRST_ID + 32'd1;
      sw_q       <= 1'b0;
      status_q   <= STS_OK;
      created_q  <= '0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      iss_cnt_q <= iss_cnt_d;
      status_q  <= status_d;
      if (state_q == ST_CLR) begin
        clr_q <= next_slot(clr_q);
      end
      if (state_q == ST_IDLE && req_valid_i) begin
        sw_q      <= 1'b0;
        created_q <= '0;
      end
      if (state_q == ST_SCAN && hit && kind_q == K_CREATE && create_ok) begin
        created_q <= id_ctr_q;
        id_ctr_q  <= id_ctr_q + 32'd1;
      end
      if (state_q == ST_WCAND) begin
        cur_slot_q <= cand_q;
        cur_id_q   <= cand_rec_q.id;
        sw_q       <= (cand_q != cur_slot_q);
      end else if (we && waddr == cur_slot_q && state_q != ST_CLR) begin
        cur_id_q <= wdata.id;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_idx_q <= iss_idx_d;
    cur_rec_q <= cur_rec_d;
    if (issue) begin
      pidx_q  <= iss_idx_q;
      plast_q <= (iss_cnt_q == CntW'(TASK_SLOTS - 1));
    end
    if (state_q == ST_IDLE && req_valid_i) begin
      kind_q  <= req_i.kind;
      id_in_q <= req_i.task_id;
      prio_q  <= req_i.priority_req;
      entry_q <= req_i.entry_address;
    end
    if (state_q == ST_SRCH && hit) begin
      cand_q     <= pidx_q;
      cand_rec_q <= '{active: rec_sel.active, state: RS_RUNNING, id: rec_sel.id,
                      slice: rec_sel.slice, ticks: rec_sel.slice};
    end
  end

  always_comb begin
    res_o              = '0;
    res_o.status       = status_q;
    res_o.running_slot = 4'(cur_slot_q);
    res_o.running_id   = cur_id_q;
    res_o.switched     = sw_q;
    res_o.created_id   = created_q;
  end

  `ASSERT_PROP(a_cur_slot_hold, (state_q != ST_WCAND) |=> $stable(cur_slot_q), "current slot moved outside a switch")
  `ASSERT_ALWAYS(a_no_write_in_scan, !(scanning && !hit && !(pend_q && plast_q)) || !we, "table write during a scan")
  `ASSERT_PROP(a_id_ctr_hold, (state_q != ST_SCAN) |=> $stable(id_ctr_q), "id counter moved outside a create")
endmodule
`default_nettype wire

// File: hdl/round_robin_task_scheduler_unit.sv
// Top level of the round-robin task scheduler with its response register
//
//  channel  dir  modport         payload
//  req_i    in   rrts_req_if     kind, task_id, priority_req, entry_address
//  rsp_o    out  rrts_rsp_if     status, running_slot, running_id, switched, created_id
//
// After reset a clearing pass writes every slot of the task table, with req_i not ready.
// A tick that keeps the current task reads and writes back only its slot; a lookup or create
// walks the table and a reschedule walks it once more, all bound by the one table read port
// walked one slot per cycle.
// The response register lets the next request enter while a response waits on rsp_o.
`default_nettype none
module round_robin_task_scheduler_unit import rrts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rrts_req_if.sink   req_i,
  rrts_rsp_if.source rsp_o
);
  logic res_valid, res_ready;
  rsp_t res;
  logic out_valid_q;
  rsp_t out_data_q;

  rrts_seq #(.TASK_SLOTS(TASK_SLOTS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_i.data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready   = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench of the round-robin task scheduler unit
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rrts_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [2:0] K_SPARE6 = 3'd6;
  localparam logic [2:0] K_SPARE7 = 3'd7;

  logic clk_i;
  logic rst_ni;

  rrts_req_if req_if ();
  rrts_rsp_if rsp_if ();

  round_robin_task_scheduler_unit #(.TASK_SLOTS(SLOTS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  int sent_cnt = 0;
  int rsp_cnt = 0;
  int create_cnt = 0;

  logic        act[SLOTS];
  run_e        run[SLOTS];
  logic [31:0] tid[SLOTS];
  logic [7:0]  slc[SLOTS];
  logic [7:0]  left[SLOTS];
  logic [3:0]  cur_slot;
  logic [31:0] next_id;

  function automatic void table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      act[i] = 1'b0; run[i] = RS_READY; tid[i] = '0; slc[i] = '0; left[i] = '0;
    end
    act[0] = 1'b1; run[0] = RS_RUNNING; tid[0] = FIRST_ID;
    slc[0] = FULL_SLICE; left[0] = FULL_SLICE;
    cur_slot = '0;
    next_id = FIRST_ID + 32'd1;
  endfunction

  function automatic void advance_slice();
    logic [3:0] c;
    logic [3:0] cand;
    c = cur_slot;
    if (left[c] > 0) left[c] = left[c] - 8'd1;
    if (left[c] > 0 && run[c] == RS_RUNNING) return;
    for (int n = 1; n <= SLOTS; n++) begin
      cand = 4'((int'(c) + n) % SLOTS);
      if (act[cand] && (run[cand] == RS_READY || run[cand] == RS_RUNNING)) begin
        left[cand] = slc[cand];
        if (run[c] == RS_RUNNING) run[c] = RS_READY;
        cur_slot = cand;
        run[cand] = RS_RUNNING;
        return;
      end
    end
    left[c] = slc[c];
  endfunction

  function automatic rsp_t schedule_request(req_t r);
    rsp_t o;
    logic [3:0] prev;
    int s;
    prev = cur_slot;
    o = '0;
    s = -1;
    o.status = STS_OK;
    case (r.kind)
      K_TICK: advance_slice();
      K_CREATE: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!act[i]) s = i;
        if (s < 0) o.status = STS_NO_SLOT;
        else if (r.entry_address == '0) o.status = STS_ZERO_ENTRY;
        else begin
          o.created_id = next_id;
          next_id = next_id + 32'd1;
          act[s] = 1'b1; run[s] = RS_READY; tid[s] = o.created_id;
          slc[s] = r.priority_req; left[s] = r.priority_req;
        end
      end
      K_BLOCK, K_UNBLOCK, K_PRIO, K_REMOVE: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (act[i] && tid[i] == r.task_id) s = i;
        if (s < 0) o.status = STS_NOT_FOUND;
        else if (r.kind == K_BLOCK) begin
          run[s] = RS_BLOCKED;
          if (s == int'(prev)) advance_slice();
        end else if (r.kind == K_UNBLOCK) begin
          run[s] = RS_READY; left[s] = slc[s];
        end else if (r.kind == K_PRIO) begin
          slc[s] = r.priority_req; left[s] = r.priority_req;
        end else if (tid[s] == FIRST_ID) o.status = STS_PROTECTED;
        else begin
          act[s] = 1'b0; run[s] = RS_READY; tid[s] = '0; slc[s] = '0; left[s] = '0;
          if (s == int'(prev)) advance_slice();
        end
      end
      default: ;
    endcase
    o.running_slot = cur_slot;
    o.running_id = tid[cur_slot];
    o.switched = (cur_slot != prev);
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      table_reset();
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_rsps.push_back(schedule_request(req_if.data));
        sent_cnt++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() > 0 &&
            ((sent_cnt >= 450 && sent_cnt < 560) || $urandom_range(99) >= 13)) begin
          req_if.valid <= 1'b1;
          req_if.data <= pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_cnt++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %0h", $realtime,
                   rsp_if.data);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("status", 32'(e.status), 32'(rsp_if.data.status));
          check_field("running_slot", 32'(e.running_slot), 32'(rsp_if.data.running_slot));
          check_field("running_id", e.running_id, rsp_if.data.running_id);
          check_field("switched", 32'(e.switched), 32'(rsp_if.data.switched));
          check_field("created_id", e.created_id, rsp_if.data.created_id);
        end
      end
      if (!hold_done && rsp_cnt == 250) begin
        hold_done = 1;
        hold_left = 300;
      end
      if (hold_left > 0) hold_left--;
      rsp_if.ready <= (hold_left == 0) &&
                      ((rsp_cnt >= 450 && rsp_cnt < 560) || $urandom_range(99) >= 13);
    end
  end

  function automatic req_t mk_req(logic [2:0] k, logic [31:0] id, logic [7:0] pr,
                                  logic [31:0] ent);
    req_t r;
    r.kind = k; r.task_id = id; r.priority_req = pr; r.entry_address = ent;
    return r;
  endfunction

  function automatic logic [31:0] pick_id();
    int lo;
    int sel;
    lo = (create_cnt > 24) ? create_cnt - 24 : 0;
    sel = $urandom_range(99);
    if (sel < 10) return $urandom();
    if (sel < 15) return FIRST_ID;
    return FIRST_ID + 32'd1 + 32'($urandom_range(create_cnt + 1, lo));
  endfunction

  function automatic logic [7:0] pick_prio();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return 8'd0;
    if (sel < 8) return 8'd255;
    if (sel < 15) return 8'($urandom());
    return 8'($urandom_range(6, 1));
  endfunction

  task automatic push_random(int n);
    int sel;
    logic [31:0] ent;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      ent = ($urandom_range(9) == 0) ? 32'd0 : ($urandom() | 32'd1) ^ 32'($urandom_range(1));
      if (sel < 40) pending_reqs.push_back(mk_req(K_TICK, $urandom(), 8'($urandom()), $urandom()));
      else if (sel < 58) begin
        if (ent != 0) create_cnt++;
        pending_reqs.push_back(mk_req(K_CREATE, $urandom(), pick_prio(), ent));
      end
      else if (sel < 68)
        pending_reqs.push_back(mk_req(K_BLOCK, pick_id(), 8'($urandom()), ent));
      else if (sel < 80)
        pending_reqs.push_back(mk_req(K_UNBLOCK, pick_id(), 8'($urandom()), ent));
      else if (sel < 88) pending_reqs.push_back(mk_req(K_PRIO, pick_id(), pick_prio(), ent));
      else if (sel < 98)
        pending_reqs.push_back(mk_req(K_REMOVE, pick_id(), 8'($urandom()), ent));
      else pending_reqs.push_back(mk_req($urandom_range(1) ? K_SPARE6 : K_SPARE7,
                                         $urandom(), 8'($urandom()), $urandom()));
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    fork
      forever #6 clk_i = ~clk_i;
    join_none
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    pending_reqs.push_back(mk_req(K_TICK, '0, '0, '0));
    pending_reqs.push_back(mk_req(K_CREATE, '0, 8'd4, 32'd0));
    pending_reqs.push_back(mk_req(K_CREATE, '0, 8'd0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(K_CREATE, '0, 8'd255, 32'd1));
    pending_reqs.push_back(mk_req(K_CREATE, '0, 8'd2, 32'h8000_0000));
    create_cnt = 3;
    pending_reqs.push_back(mk_req(K_TICK, '0, '0, '0));
    pending_reqs.push_back(mk_req(K_BLOCK, FIRST_ID, '0, '0));
    pending_reqs.push_back(mk_req(K_UNBLOCK, FIRST_ID, '0, '0));
    pending_reqs.push_back(mk_req(K_PRIO, FIRST_ID + 32'd1, 8'd3, '0));
    pending_reqs.push_back(mk_req(K_REMOVE, FIRST_ID, '0, '0));
    pending_reqs.push_back(mk_req(K_REMOVE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(K_SPARE6, '0, '0, '0));
    pending_reqs.push_back(mk_req(K_SPARE7, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(K_REMOVE, FIRST_ID + 32'd2, '0, '0));
    pending_reqs.push_back(mk_req(K_TICK, '0, '0, '0));
    for (int i = 0; i < 14; i++)
      pending_reqs.push_back(mk_req(K_CREATE, '0, 8'(i), 32'(i + 5)));
    create_cnt += 13;
    push_random(330);
    wait_drained();
    push_random(390);
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
